// ----- sv/amt_pkg.sv -----
// Shared constants, types and state codes of the adaptive mean threshold block.
package amt_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HALF   = 15;
	localparam int PIXEL_BITS = 8;
	localparam int MAX_HEIGHT = 4096;

	localparam int WID_W  = 11;
	localparam int HGT_W  = 13;
	localparam int HALF_W = 4;
	localparam int OFF_W  = 9;
	localparam int DATA_W = 13;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int IROW_W = OROW_W + 1;
	localparam int LIN_W  = 24;

	localparam int STORE_SIZE = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	localparam int SPAN_W  = $clog2(2 * MAX_HALF + 1);
	localparam int WIN_MAX = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
	localparam int CNT_W   = $clog2(WIN_MAX + 1);
	localparam int SUM_W   = $clog2(WIN_MAX * 255 + 1);

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_HALF,
		REG_OFFSET
	} amt_reg_t;

	typedef struct packed {
		logic [WID_W-1:0]        width;
		logic [HGT_W-1:0]        height;
		logic [HALF_W-1:0]       half;
		logic signed [OFF_W-1:0] offset;
	} amt_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G0,
		ST_G1,
		ST_G2,
		ST_G3,
		ST_DECIDE,
		ST_WIN0,
		ST_WIN1,
		ST_WIN2,
		ST_SWEEP,
		ST_DRAIN,
		ST_DIVGO,
		ST_DIVW,
		ST_EMIT
	} amt_state_t;

endpackage

// ----- sv/amt_in_if.sv -----
// Pixel input channel: valid/ready handshake with pixel and flush mark.
interface amt_in_if;
	logic                            valid;
	logic                            ready;
	logic [amt_pkg::PIXEL_BITS-1:0]  pixel;
	logic                            is_flush;

	modport source (output valid, output pixel, output is_flush, input ready);
	modport sink (input valid, input pixel, input is_flush, output ready);
endinterface

// ----- sv/amt_out_if.sv -----
// Result output channel: valid/ready handshake with threshold decision.
interface amt_out_if;
	logic valid;
	logic ready;
	logic above;
	logic frame_end;

	modport source (output valid, output above, output frame_end, input ready);
	modport sink (input valid, input above, input frame_end, output ready);
endinterface

// ----- sv/amt_cfg.sv -----
// Configuration registers with saturation to the supported geometry.
module amt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [amt_pkg::DATA_W-1:0] wr_data,
	output amt_pkg::amt_cfg_t          cfg
);

	logic [amt_pkg::WID_W-1:0]  width_q;
	logic [amt_pkg::HGT_W-1:0]  height_q;
	logic [amt_pkg::HALF_W-1:0] half_q;
	logic [amt_pkg::OFF_W-1:0]  offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= amt_pkg::WID_W'(640);
			height_q <= amt_pkg::HGT_W'(480);
			half_q   <= amt_pkg::HALF_W'(15);
			offset_q <= amt_pkg::OFF_W'(15);
		end else if (wr_en) begin
			case (amt_pkg::amt_reg_t'(wr_index))
				amt_pkg::REG_WIDTH:  width_q  <= wr_data[amt_pkg::WID_W-1:0];
				amt_pkg::REG_HEIGHT: height_q <= wr_data[amt_pkg::HGT_W-1:0];
				amt_pkg::REG_HALF:   half_q   <= wr_data[amt_pkg::HALF_W-1:0];
				amt_pkg::REG_OFFSET: offset_q <= wr_data[amt_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			cfg.width = amt_pkg::WID_W'(1);
		else if (width_q > amt_pkg::WID_W'(amt_pkg::MAX_WIDTH))
			cfg.width = amt_pkg::WID_W'(amt_pkg::MAX_WIDTH);
		else
			cfg.width = width_q;
		if (height_q == '0)
			cfg.height = amt_pkg::HGT_W'(1);
		else if (height_q > amt_pkg::HGT_W'(amt_pkg::MAX_HEIGHT))
			cfg.height = amt_pkg::HGT_W'(amt_pkg::MAX_HEIGHT);
		else
			cfg.height = height_q;
		if (half_q > amt_pkg::HALF_W'(amt_pkg::MAX_HALF))
			cfg.half = amt_pkg::HALF_W'(amt_pkg::MAX_HALF);
		else
			cfg.half = half_q;
		cfg.offset = $signed(offset_q);
	end

endmodule

// ----- sv/amt_line_mem.sv -----
// Pixel line store: one write port, one registered read port.
module amt_line_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [amt_pkg::ADDR_W-1:0]     wa,
	input  logic [amt_pkg::PIXEL_BITS-1:0] wd,
	input  logic                           re,
	input  logic [amt_pkg::ADDR_W-1:0]     ra,
	output logic [amt_pkg::PIXEL_BITS-1:0] rd
);

	logic [amt_pkg::PIXEL_BITS-1:0] mem [amt_pkg::STORE_SIZE];

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (re)
			rd <= mem[ra];
	end

endmodule

// ----- sv/amt_div.sv -----
// Restoring divider for the window mean, one quotient bit per cycle.
module amt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [amt_pkg::SUM_W-1:0] dividend,
	input  logic [amt_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [amt_pkg::SUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(amt_pkg::SUM_W + 1);

	logic [amt_pkg::CNT_W-1:0] rem_q;
	logic [amt_pkg::SUM_W-1:0] quo_q;
	logic [amt_pkg::CNT_W-1:0] dsr_q;
	logic [STEP_W-1:0]         step_q;
	logic                      done_q;
	logic [amt_pkg::CNT_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, quo_q[amt_pkg::SUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				step_q <= STEP_W'(amt_pkg::SUM_W);
			else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? amt_pkg::CNT_W'(trial - {1'b0, dsr_q})
				: trial[amt_pkg::CNT_W-1:0];
			quo_q <= {quo_q[amt_pkg::SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/adaptive_mean_threshold.sv -----
// Adaptive mean threshold over a clipped box window, pixels in raster order.
// An item that yields no result holds the input from its accepting IDLE state through G0 to G3 and DECIDE.
// An item that yields a result then reads its clipped window of R rows and C columns serially from the
// line store, runs the 18-step divider and waits in EMIT while the output is stalled.
// Results lag their pixel by half rows plus half pixels of input items.
// Reset restores the power-on geometry and zeroes the input and output positions; the line store is not cleared.
module adaptive_mean_threshold (
	input  logic                       clk,
	input  logic                       arst_n,
	amt_in_if.sink                     pixels,
	amt_out_if.source                  results,
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [amt_pkg::DATA_W-1:0] wr_data
);

	localparam int AW = amt_pkg::ADDR_W;
	localparam int LW = amt_pkg::LIN_W;
	localparam int HW = amt_pkg::HGT_W;
	localparam int SW = amt_pkg::SPAN_W;

	amt_pkg::amt_cfg_t   cfg;
	amt_pkg::amt_state_t state_q, state_d;

	logic [amt_pkg::PIXEL_BITS-1:0] pix_q, centre_q, mem_rd;
	logic                           flush_q;
	logic [LW-1:0]                  total_q, pos_q, qlin_q, lag_q;
	logic [amt_pkg::COL_W-1:0]      in_col_q, out_col_q;
	logic [amt_pkg::IROW_W-1:0]     in_row_q;
	logic [amt_pkg::OROW_W-1:0]     out_row_q;
	logic [AW-1:0]                  wa_q, qa_q, off_q, rs_q, ra_q;
	logic [amt_pkg::HALF_W-1:0]     dr_q, dc_q;
	logic [SW-1:0]                  nrows_q, ncols_q, i_q, j_q;
	logic                           rd_pend_q;
	logic [amt_pkg::SUM_W-1:0]      sum_q, quo;
	logic [amt_pkg::CNT_W-1:0]      cnt_q;
	logic                           res_valid_q, res_above_q, res_end_q;

	// Shared multiplier for the frame size, the linear positions, the result lag and the window start offset.
	logic [HW-1:0] mul_a;
	logic [amt_pkg::COL_W-1:0] mul_add;
	logic [LW-1:0] mul_p;

	// Item decision signals.
	logic                      wrap, live, adv, need_res;
	logic [LW-1:0]             p_eff, q_eff;
	logic [amt_pkg::COL_W-1:0] ic_base, ic_next;
	logic [amt_pkg::IROW_W-1:0] ir_base, ir_next;

	// Window bounds.
	logic [HW-1:0] wr_r, wr_hf, wr_r0, wr_r1, wr_hlast;
	logic [HW-1:0] wc_c, wc_c0, wc_c1, wc_wlast;

	logic [AW:0]   start_addr, row_step;
	logic [AW-1:0] ra_inc, qa_inc, wa_base, wa_inc;

	logic mem_we, mem_re;
	logic [AW-1:0] mem_ra;
	logic div_start, div_done, emit_fire;
	logic [LW-1:0] q_next;
	logic signed [10:0] thr;

	amt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	amt_line_mem u_mem (
		.clk (clk),
		.we  (mem_we),
		.wa  (wa_base),
		.wd  (pix_q),
		.re  (mem_re),
		.ra  (mem_ra),
		.rd  (mem_rd)
	);

	amt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		mul_a   = '0;
		mul_add = '0;
		case (state_q)
			amt_pkg::ST_G0: mul_a = cfg.height;
			amt_pkg::ST_G1: begin
				mul_a   = HW'(in_row_q);
				mul_add = in_col_q;
			end
			amt_pkg::ST_G2: begin
				mul_a   = HW'(out_row_q);
				mul_add = out_col_q;
			end
			amt_pkg::ST_G3: begin
				mul_a   = HW'(cfg.half);
				mul_add = amt_pkg::COL_W'(cfg.half);
			end
			amt_pkg::ST_WIN1: begin
				mul_a   = HW'(dr_q);
				mul_add = amt_pkg::COL_W'(dc_q);
			end
			default: ;
		endcase
		mul_p = LW'(mul_a) * LW'(cfg.width) + LW'(mul_add);
	end

	// A finished frame clears all positions before the item is looked at.
	always_comb begin
		wrap     = qlin_q >= total_q;
		p_eff    = wrap ? '0 : pos_q;
		q_eff    = wrap ? '0 : qlin_q;
		live     = p_eff < total_q;
		adv      = !live || !flush_q;
		need_res = (p_eff + 1'b1) > (q_eff + lag_q);
		ic_base  = wrap ? '0 : in_col_q;
		ir_base  = wrap ? '0 : in_row_q;
		wa_base  = wrap ? '0 : wa_q;
		wa_inc   = (wa_base == AW'(amt_pkg::STORE_SIZE - 1)) ? '0 : wa_base + 1'b1;
		if ((amt_pkg::WID_W'(ic_base) + 1'b1) >= cfg.width) begin
			ic_next = '0;
			ir_next = ir_base + 1'b1;
		end else begin
			ic_next = ic_base + 1'b1;
			ir_next = ir_base;
		end
	end

	always_comb begin
		wr_r     = HW'(out_row_q);
		wr_hf    = HW'(cfg.half);
		wr_hlast = cfg.height - 1'b1;
		wr_r0    = (wr_r >= wr_hf) ? wr_r - wr_hf : '0;
		wr_r1    = ((wr_r + wr_hf) > wr_hlast) ? wr_hlast : wr_r + wr_hf;
		wc_c     = HW'(out_col_q);
		wc_wlast = HW'(cfg.width) - 1'b1;
		wc_c0    = (wc_c >= wr_hf) ? wc_c - wr_hf : '0;
		wc_c1    = ((wc_c + wr_hf) > wc_wlast) ? wc_wlast : wc_c + wr_hf;
	end

	always_comb begin
		start_addr = (qa_q >= off_q) ? {1'b0, qa_q - off_q}
			: {1'b0, qa_q} + (AW + 1)'(amt_pkg::STORE_SIZE) - {1'b0, off_q};
		row_step = {1'b0, rs_q} + (AW + 1)'(cfg.width);
		if (row_step >= (AW + 1)'(amt_pkg::STORE_SIZE))
			row_step = row_step - (AW + 1)'(amt_pkg::STORE_SIZE);
		ra_inc = (ra_q == AW'(amt_pkg::STORE_SIZE - 1)) ? '0 : ra_q + 1'b1;
		qa_inc = (qa_q == AW'(amt_pkg::STORE_SIZE - 1)) ? '0 : qa_q + 1'b1;
		q_next = qlin_q + 1'b1;
		thr    = $signed({2'b00, quo[8:0]}) - 11'(cfg.offset);
	end

	assign emit_fire = (state_q == amt_pkg::ST_EMIT) && (!res_valid_q || results.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			amt_pkg::ST_IDLE:   if (pixels.valid) state_d = amt_pkg::ST_G0;
			amt_pkg::ST_G0:     state_d = amt_pkg::ST_G1;
			amt_pkg::ST_G1:     state_d = amt_pkg::ST_G2;
			amt_pkg::ST_G2:     state_d = amt_pkg::ST_G3;
			amt_pkg::ST_G3:     state_d = amt_pkg::ST_DECIDE;
			amt_pkg::ST_DECIDE:
				state_d = (adv && need_res) ? amt_pkg::ST_WIN0 : amt_pkg::ST_IDLE;
			amt_pkg::ST_WIN0:   state_d = amt_pkg::ST_WIN1;
			amt_pkg::ST_WIN1:   state_d = amt_pkg::ST_WIN2;
			amt_pkg::ST_WIN2:   state_d = amt_pkg::ST_SWEEP;
			amt_pkg::ST_SWEEP:
				if (i_q == ncols_q && j_q == nrows_q) state_d = amt_pkg::ST_DRAIN;
			amt_pkg::ST_DRAIN:  state_d = amt_pkg::ST_DIVGO;
			amt_pkg::ST_DIVGO:  state_d = amt_pkg::ST_DIVW;
			amt_pkg::ST_DIVW:   if (div_done) state_d = amt_pkg::ST_EMIT;
			amt_pkg::ST_EMIT:   if (emit_fire) state_d = amt_pkg::ST_IDLE;
			default:            state_d = amt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pixels.ready = state_q == amt_pkg::ST_IDLE;
		mem_we       = (state_q == amt_pkg::ST_DECIDE) && live && !flush_q;
		mem_re       = (state_q == amt_pkg::ST_WIN0) || (state_q == amt_pkg::ST_SWEEP);
		mem_ra       = (state_q == amt_pkg::ST_WIN0) ? qa_q : ra_q;
		div_start    = state_q == amt_pkg::ST_DIVGO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amt_pkg::ST_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			qlin_q      <= '0;
			wa_q        <= '0;
			qa_q        <= '0;
			rd_pend_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= state_q == amt_pkg::ST_SWEEP;
			if (results.ready)
				res_valid_q <= 1'b0;
			if (emit_fire)
				res_valid_q <= 1'b1;
			case (state_q)
				// The next result position follows the current row width.
				amt_pkg::ST_G2: qlin_q <= mul_p;
				amt_pkg::ST_DECIDE: begin
					if (wrap) begin
						out_col_q <= '0;
						out_row_q <= '0;
						qa_q      <= '0;
						qlin_q    <= '0;
					end
					if (adv) begin
						in_col_q <= ic_next;
						in_row_q <= ir_next;
						wa_q     <= wa_inc;
					end else begin
						in_col_q <= ic_base;
						in_row_q <= ir_base;
						wa_q     <= wa_base;
					end
				end
				amt_pkg::ST_EMIT: begin
					if (emit_fire) begin
						if (q_next >= total_q) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							qlin_q    <= '0;
							wa_q      <= '0;
							qa_q      <= '0;
						end else begin
							qlin_q <= q_next;
							qa_q   <= qa_inc;
							if ((amt_pkg::WID_W'(out_col_q) + 1'b1) >= cfg.width) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + 1'b1;
							end else
								out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.valid && pixels.ready) begin
			pix_q   <= pixels.pixel;
			flush_q <= pixels.is_flush;
		end
		case (state_q)
			amt_pkg::ST_G0: total_q <= mul_p;
			amt_pkg::ST_G1: pos_q   <= mul_p;
			amt_pkg::ST_G3: lag_q   <= mul_p;
			amt_pkg::ST_WIN0: begin
				dr_q    <= amt_pkg::HALF_W'(wr_r - wr_r0);
				dc_q    <= amt_pkg::HALF_W'(wc_c - wc_c0);
				nrows_q <= SW'(wr_r1 - wr_r0);
				ncols_q <= SW'(wc_c1 - wc_c0);
			end
			amt_pkg::ST_WIN1: begin
				centre_q <= mem_rd;
				off_q    <= AW'(mul_p);
			end
			amt_pkg::ST_WIN2: begin
				rs_q  <= AW'(start_addr);
				ra_q  <= AW'(start_addr);
				i_q   <= '0;
				j_q   <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end
			amt_pkg::ST_SWEEP: begin
				if (i_q == ncols_q) begin
					i_q  <= '0;
					j_q  <= j_q + 1'b1;
					rs_q <= AW'(row_step);
					ra_q <= AW'(row_step);
				end else begin
					i_q  <= i_q + 1'b1;
					ra_q <= ra_inc;
				end
			end
			default: ;
		endcase
		if (rd_pend_q) begin
			sum_q <= sum_q + amt_pkg::SUM_W'(mem_rd);
			cnt_q <= cnt_q + 1'b1;
		end
		if (emit_fire) begin
			res_above_q <= $signed({3'b000, centre_q}) > thr;
			res_end_q   <= qlin_q == (total_q - 1'b1);
		end
	end

	assign results.valid     = res_valid_q;
	assign results.above     = res_above_q;
	assign results.frame_end = res_end_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |=> state_q == amt_pkg::ST_G0)
		else $error("accepted request did not start the position pass");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == amt_pkg::ST_DIVW)
		else $error("divider finished outside its wait state");

	a_window_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> cnt_q < amt_pkg::CNT_W'(amt_pkg::WIN_MAX))
		else $error("window sweep read more pixels than a full window");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> results.valid)
		else $error("emitted result not presented on the output");

endmodule
